// File: rtl/bmhq_pkg.sv
// Package for the binary min-heap queue: field widths, operation and status
// codes, controller states and the command/status structs between the
// controller and the datapath. Depends on nothing.
package bmhq_pkg;

  // Fixed widths of the word fields.
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int ENTRY_W  = 7;
  localparam int STATUS_W = 2;

  // Default heap capacity.
  localparam int CAPACITY_DEF = 64;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 3'd0,
    MODE_EXTRACT = 3'd1,
    MODE_LOAD    = 3'd2,
    MODE_BUILD   = 3'd3,
    MODE_VERIFY  = 3'd4
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOTHEAP = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXT_V,
    S_BLD_RD,
    S_BLD_V,
    S_UP_RD,
    S_UP_CMP,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_WR_V,
    S_VER_RD,
    S_VER_RP,
    S_VER_CMP,
    S_DONE
  } state_t;

  // Source of the next sift position.
  typedef enum logic [2:0] {
    POS_HOLD,
    POS_NEW,
    POS_ONE,
    POS_PARENT,
    POS_BEST,
    POS_CUR
  } pos_src_t;

  // Source of the next outer cursor (build and verify).
  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_HALF,
    CUR_LAST,
    CUR_DEC
  } cur_src_t;

  // Read address select.
  typedef enum logic [2:0] {
    RD_LAST,
    RD_LEFT,
    RD_RIGHT,
    RD_PARENT,
    RD_CUR,
    RD_CUR_PARENT
  } rd_src_t;

  // Write select; the write address is always the sift position.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_V,
    WR_RD,
    WR_BEST
  } wr_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_val;
    logic     min_cap;
    logic     cnt_inc;
    logic     cnt_dec;
    pos_src_t pos_src;
    cur_src_t cur_src;
    rd_src_t  rd_src;
    logic     cap_a;
    logic     v_from_rd;
    wr_src_t  wr_src;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic small_cnt;
    logic pos_is_root;
    logic l_in;
    logic up_swap;
    logic dn_move;
    logic ver_fail;
    logic cur_is_one;
    logic cur_is_two;
  } dp_stat_t;

endpackage

// File: rtl/bmhq_in_if.sv
// Input channel of the binary min-heap queue: valid, ready, mode and value.
// Depends on bmhq_pkg for the field widths.
interface bmhq_in_if import bmhq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [MODE_W-1:0]  mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// File: rtl/bmhq_out_if.sv
// Result channel of the binary min-heap queue: valid, ready, minimum, count
// and status. Depends on bmhq_pkg for the field widths.
interface bmhq_out_if import bmhq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  min_value;
  logic        [ENTRY_W-1:0]  entry_count;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, output min_value, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input min_value, input entry_count, input status,
                  output ready);
endinterface

// File: rtl/bmhq_datapath.sv
// Datapath of the binary min-heap queue: heap store memory, count, sift
// position, cursor and comparators. Depends on bmhq_pkg.
module bmhq_datapath import bmhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  input  logic signed [VALUE_W-1:0] in_value,
  output dp_stat_t                  stat,
  output logic signed [VALUE_W-1:0] min_value,
  output logic [$clog2(CAPACITY+1)-1:0] count
);

  localparam int CW = $clog2(CAPACITY + 1);

  // Store positions 1..CAPACITY; position 0 is never used.
  logic signed [VALUE_W-1:0] mem [CAPACITY+1];

  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic [CW-1:0]             cur_r, cur_nxt;
  logic signed [VALUE_W-1:0] v_r, a_r, min_r, root_r, rd_data_r;
  logic                      have_min_r;

  logic [CW:0]               left_w, right_w;
  logic                      r_in;
  logic [CW-1:0]             rd_addr;
  logic                      wr_en;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      take_l, take_r;
  logic signed [VALUE_W-1:0] lv_best, best_val;
  logic [CW-1:0]             best_pos;

  // Child positions of the sift position, one bit wider than a position.
  assign left_w  = {pos_r, 1'b0};
  assign right_w = {pos_r, 1'b1};
  assign r_in    = (right_w <= {1'b0, count_r});

  // Smallest of the held value and its children; ties keep the parent.
  assign take_l   = (v_r > a_r);
  assign lv_best  = take_l ? a_r : v_r;
  assign take_r   = r_in && (lv_best > rd_data_r);
  assign best_val = take_r ? rd_data_r : lv_best;
  assign best_pos = take_r ? right_w[CW-1:0] : left_w[CW-1:0];

  // Read address selection.
  always_comb begin
    unique case (cmd.rd_src)
      RD_LAST:       rd_addr = count_r;
      RD_LEFT:       rd_addr = left_w[CW-1:0];
      RD_RIGHT:      rd_addr = r_in ? right_w[CW-1:0] : left_w[CW-1:0];
      RD_PARENT:     rd_addr = pos_r >> 1;
      RD_CUR:        rd_addr = cur_r;
      RD_CUR_PARENT: rd_addr = cur_r >> 1;
      default:       rd_addr = cur_r;
    endcase
  end

  // Write data selection; writes always go to the sift position.
  always_comb begin
    wr_en   = 1'b1;
    wr_data = v_r;
    unique case (cmd.wr_src)
      WR_NONE: wr_en   = 1'b0;
      WR_V:    wr_data = v_r;
      WR_RD:   wr_data = rd_data_r;
      WR_BEST: wr_data = best_val;
      default: wr_en   = 1'b0;
    endcase
  end

  // Memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Next position, cursor and count.
  always_comb begin
    unique case (cmd.pos_src)
      POS_HOLD:   pos_nxt = pos_r;
      POS_NEW:    pos_nxt = CW'(count_r + 1'b1);
      POS_ONE:    pos_nxt = CW'(1);
      POS_PARENT: pos_nxt = pos_r >> 1;
      POS_BEST:   pos_nxt = best_pos;
      POS_CUR:    pos_nxt = cur_r;
      default:    pos_nxt = pos_r;
    endcase
    unique case (cmd.cur_src)
      CUR_HOLD: cur_nxt = cur_r;
      CUR_HALF: cur_nxt = count_r >> 1;
      CUR_LAST: cur_nxt = count_r;
      CUR_DEC:  cur_nxt = CW'(cur_r - 1'b1);
      default:  cur_nxt = cur_r;
    endcase
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (cmd.cnt_dec) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      have_min_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.min_cap) begin
        have_min_r <= 1'b1;
      end else if (cmd.load_val) begin
        have_min_r <= 1'b0;
      end
    end
  end

  // Payload registers; the root copy follows every write to position one.
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    cur_r <= cur_nxt;
    if (cmd.load_val) begin
      v_r <= in_value;
    end else if (cmd.v_from_rd) begin
      v_r <= rd_data_r;
    end
    if (cmd.cap_a) begin
      a_r <= rd_data_r;
    end
    if (cmd.min_cap) begin
      min_r <= root_r;
    end
    if (wr_en && (pos_r == CW'(1))) begin
      root_r <= wr_data;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.full        = (count_r == CW'(CAPACITY));
    stat.empty       = (count_r == '0);
    stat.small_cnt   = (count_r < CW'(2));
    stat.pos_is_root = (pos_r == CW'(1));
    stat.l_in        = (left_w <= {1'b0, count_r});
    stat.up_swap     = (v_r < rd_data_r);
    stat.dn_move     = take_l || take_r;
    stat.ver_fail    = (a_r < rd_data_r);
    stat.cur_is_one  = (cur_r == CW'(1));
    stat.cur_is_two  = (cur_r == CW'(2));
  end

  // Result fields.
  assign min_value = have_min_r ? min_r : ((count_r != '0) ? root_r : '0);
  assign count     = count_r;

endmodule

// File: rtl/bmhq_ctrl.sv
// Controller of the binary min-heap queue: sequences every operation as
// memory reads, compares and writes in the datapath. Depends on bmhq_pkg.
module bmhq_ctrl import bmhq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  logic              out_free,
  output logic              out_load,
  output status_t           res_status,
  output dp_cmd_t           cmd,
  input  dp_stat_t          stat
);

  state_t  state_r, state_nxt;
  status_t stat_r, stat_nxt;
  logic    bld_r, bld_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stat_r  <= ST_OK;
      bld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
      bld_r   <= bld_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    bld_nxt   = bld_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_val = 1'b1;
          stat_nxt     = ST_OK;
          bld_nxt      = 1'b0;
          state_nxt    = S_DONE;
          unique case (in_mode)
            MODE_INSERT, MODE_LOAD: begin
              if (stat.full) begin
                stat_nxt = ST_FULL;
              end else begin
                cmd.cnt_inc = 1'b1;
                cmd.pos_src = POS_NEW;
                state_nxt   = (in_mode == MODE_INSERT) ? S_UP_RD : S_WR_V;
              end
            end
            MODE_EXTRACT: begin
              if (stat.empty) begin
                stat_nxt = ST_EMPTY;
              end else begin
                cmd.min_cap = 1'b1;
                cmd.rd_src  = RD_LAST;
                cmd.cnt_dec = 1'b1;
                cmd.pos_src = POS_ONE;
                state_nxt   = S_EXT_V;
              end
            end
            MODE_BUILD: begin
              if (!stat.small_cnt) begin
                cmd.cur_src = CUR_HALF;
                bld_nxt     = 1'b1;
                state_nxt   = S_BLD_RD;
              end
            end
            MODE_VERIFY: begin
              if (!stat.small_cnt) begin
                cmd.cur_src = CUR_LAST;
                state_nxt   = S_VER_RD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // The last entry moves to the root and sinks.
      S_EXT_V: begin
        cmd.v_from_rd = 1'b1;
        state_nxt     = S_DN_L;
      end
      // Build: fetch the parent at the cursor and sink it.
      S_BLD_RD: begin
        cmd.rd_src  = RD_CUR;
        cmd.pos_src = POS_CUR;
        state_nxt   = S_BLD_V;
      end
      S_BLD_V: begin
        cmd.v_from_rd = 1'b1;
        state_nxt     = S_DN_L;
      end
      // Sift up: compare with the parent, move the parent down if larger.
      S_UP_RD: begin
        cmd.rd_src = RD_PARENT;
        state_nxt  = stat.pos_is_root ? S_WR_V : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (stat.up_swap) begin
          cmd.wr_src  = WR_RD;
          cmd.pos_src = POS_PARENT;
          state_nxt   = S_UP_RD;
        end else begin
          state_nxt = S_WR_V;
        end
      end
      // Sift down: read both children, move the smaller one up if needed.
      S_DN_L: begin
        cmd.rd_src = RD_LEFT;
        state_nxt  = stat.l_in ? S_DN_R : S_WR_V;
      end
      S_DN_R: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_src = RD_RIGHT;
        state_nxt  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.dn_move) begin
          cmd.wr_src  = WR_BEST;
          cmd.pos_src = POS_BEST;
          state_nxt   = S_DN_L;
        end else begin
          state_nxt = S_WR_V;
        end
      end
      // Park the held value at its final place.
      S_WR_V: begin
        cmd.wr_src = WR_V;
        if (bld_r && !stat.cur_is_one) begin
          cmd.cur_src = CUR_DEC;
          state_nxt   = S_BLD_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // Verify: compare each child with its parent, last entry first.
      S_VER_RD: begin
        cmd.rd_src = RD_CUR;
        state_nxt  = S_VER_RP;
      end
      S_VER_RP: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_src = RD_CUR_PARENT;
        state_nxt  = S_VER_CMP;
      end
      S_VER_CMP: begin
        if (stat.ver_fail) begin
          stat_nxt  = ST_NOTHEAP;
          state_nxt = S_DONE;
        end else if (stat.cur_is_two) begin
          state_nxt = S_DONE;
        end else begin
          cmd.cur_src = CUR_DEC;
          state_nxt   = S_VER_RD;
        end
      end
      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_status = stat_r;

endmodule

// File: rtl/binary_min_heap_queue.sv
// Binary min-heap queue of signed 32-bit values, up to CAPACITY entries.
// One word on in_ch (mode, value) yields exactly one word on out_ch
// (min_value, entry_count, status). Modes: insert, extract minimum, load
// without ordering, build heap, verify.
// Items are taken one at a time: in_ch.ready is high only while the
// controller is idle. All work goes through the single read and single
// write port of the heap store, one controller state per step.
// The time from acceptance to out_ch.valid grows with the levels an entry
// moves on insert and extract, with each child checked on verify, and with
// each parent and level sunk on build; rejected, empty and no-op words go
// straight to the result. The next word can be taken in the same cycle
// that out_ch.valid rises.
// Results pass through an output register, so a new word is accepted while
// the last result waits; a finished result then waits inside the
// controller until the output register is free, and no word is lost.
// Reset (rst_n low, synchronous) empties the heap and drops any pending
// result; the store itself is not cleared, as count bounds every read.
// Depends on bmhq_pkg, bmhq_in_if, bmhq_out_if, bmhq_ctrl, bmhq_datapath.
module binary_min_heap_queue import bmhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bmhq_in_if.sink    in_ch,
  bmhq_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);

  dp_cmd_t                   cmd;
  dp_stat_t                  dstat;
  status_t                   res_status;
  logic signed [VALUE_W-1:0] dp_min;
  logic [CW-1:0]             dp_count;
  logic                      out_load;
  logic                      out_free;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_min_r;
  logic [ENTRY_W-1:0]        out_count_r;
  logic [STATUS_W-1:0]       out_status_r;

  assign out_free = !out_valid_r || out_ch.ready;

  // Controller.
  bmhq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_mode    (in_ch.mode),
    .in_ready   (in_ch.ready),
    .out_free   (out_free),
    .out_load   (out_load),
    .res_status (res_status),
    .cmd        (cmd),
    .stat       (dstat)
  );

  // Datapath.
  bmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_ch.value),
    .stat      (dstat),
    .min_value (dp_min),
    .count     (dp_count)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min_r    <= dp_min;
      out_count_r  <= ENTRY_W'(dp_count);
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.min_value   = out_min_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.status      = out_status_r;

`ifndef SYNTHESIS
  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dp_count <= CW'(CAPACITY))
    else $error("heap count beyond capacity");

  // An accepted word keeps the controller busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("word accepted twice in a row");

  // A full result is only ever given with the heap at capacity.
  a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (res_status == ST_FULL) |-> (dp_count == CW'(CAPACITY)))
    else $error("full status with room left");

  // An empty result carries a zero minimum and a zero count.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (res_status == ST_EMPTY) |-> (dp_count == '0) && (dp_min == '0))
    else $error("empty status with entries held");
`endif

endmodule

// File: bench/tb_binary_min_heap_queue.sv
// Self-checking testbench for the binary min-heap queue: a directed table
// followed by weighted random traffic, each word checked against its table expectation or a shadow heap.
// Depends on bmhq_pkg, bmhq_in_if, bmhq_out_if and binary_min_heap_queue.
module tb_binary_min_heap_queue import bmhq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH       = CAPACITY_DEF;
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 400;
  localparam int RANDOM_PER_PHASE = 484;
  localparam int REPORT_LIMIT     = 10;
  localparam int DIRECTED_ROWS    = 25;

  // Mode codes beyond the defined operations; the block treats them as no-ops.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic signed [VALUE_W-1:0] min_value;
    logic [ENTRY_W-1:0]        entry_count;
    status_t                   status;
  } heap_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
    logic                      typed;
    heap_result_t              want;
  } stim_row_t;

  // Operation mixes used to steer the random traffic between fill and drain.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_LOADS,
    MIX_BALANCED
  } op_mix_t;

  logic clk;
  logic rst_n;

  bmhq_in_if  in_ch ();
  bmhq_out_if out_ch ();

  binary_min_heap_queue #(.CAPACITY(HEAP_DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the heap, one-based like the block's store.
  logic signed [VALUE_W-1:0] shadow_heap [1:HEAP_DEPTH];
  int                        shadow_count = 0;
  heap_result_t              pending_results [$];
  int                        fault_count   = 0;
  int                        idle_src_pct  = 6;
  int                        idle_sink_pct = 69;

  // Directed words: typed expectations only where they are obvious.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_EXTRACT,   32'sd0,    1'b1, '{32'sd0,  7'd0, ST_EMPTY}},
    '{MODE_VERIFY,    32'sd0,    1'b1, '{32'sd0,  7'd0, ST_OK}},
    '{MODE_BUILD,     32'sd0,    1'b1, '{32'sd0,  7'd0, ST_OK}},
    '{MODE_SPARE_LO,  32'sd0,    1'b1, '{32'sd0,  7'd0, ST_OK}},
    '{MODE_INSERT,    VAL_MAX,   1'b1, '{VAL_MAX, 7'd1, ST_OK}},
    '{MODE_INSERT,    VAL_MIN,   1'b1, '{VAL_MIN, 7'd2, ST_OK}},
    '{MODE_INSERT,    32'sd0,    1'b1, '{VAL_MIN, 7'd3, ST_OK}},
    '{MODE_INSERT,    -32'sd1,   1'b0, '0},
    '{MODE_EXTRACT,   32'sd0,    1'b1, '{VAL_MIN, 7'd3, ST_OK}},
    '{MODE_EXTRACT,   VAL_MAX,   1'b0, '0},
    '{MODE_EXTRACT,   VAL_MIN,   1'b0, '0},
    '{MODE_EXTRACT,   32'sd0,    1'b1, '{VAL_MAX, 7'd0, ST_OK}},
    '{MODE_LOAD,      32'sd100,  1'b1, '{32'sd100, 7'd1, ST_OK}},
    '{MODE_LOAD,      32'sd50,   1'b1, '{32'sd100, 7'd2, ST_OK}},
    '{MODE_LOAD,      32'sd20,   1'b1, '{32'sd100, 7'd3, ST_OK}},
    '{MODE_VERIFY,    32'sd0,    1'b1, '{32'sd100, 7'd3, ST_NOTHEAP}},
    '{MODE_SPARE_MID, VAL_MIN,   1'b1, '{32'sd100, 7'd3, ST_OK}},
    '{MODE_BUILD,     32'sd0,    1'b1, '{32'sd20,  7'd3, ST_OK}},
    '{MODE_VERIFY,    32'sd0,    1'b1, '{32'sd20,  7'd3, ST_OK}},
    '{MODE_LOAD,      -32'sd5,   1'b0, '0},
    '{MODE_LOAD,      32'sd7,    1'b0, '0},
    '{MODE_SPARE_HI,  VAL_MAX,   1'b0, '0},
    '{MODE_INSERT,    32'sd5555, 1'b0, '0},
    '{MODE_BUILD,     32'sd0,    1'b0, '0},
    '{MODE_EXTRACT,   32'sd0,    1'b0, '0}
  };

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void heap_swap(int a, int b);
    logic signed [VALUE_W-1:0] held;
    held           = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = held;
  endfunction

  // Push the entry at pos down until neither child is smaller.
  function automatic void heap_sink(int pos);
    int left;
    int best;
    while (1) begin
      left = pos * 2;
      best = pos;
      if (left <= shadow_count && shadow_heap[best] > shadow_heap[left])
        best = left;
      if (left + 1 <= shadow_count && shadow_heap[best] > shadow_heap[left + 1])
        best = left + 1;
      if (best == pos)
        return;
      heap_swap(pos, best);
      pos = best;
    end
  endfunction

  // Raise the entry at pos while it is smaller than its parent.
  function automatic void heap_float(int pos);
    while (pos > 1 && shadow_heap[pos] < shadow_heap[pos / 2]) begin
      heap_swap(pos, pos / 2);
      pos = pos / 2;
    end
  endfunction

  function automatic bit heap_is_ordered();
    for (int i = shadow_count; i > 1; i--)
      if (shadow_heap[i] < shadow_heap[i / 2])
        return 1'b0;
    return 1'b1;
  endfunction

  // Apply one operation to the shadow heap and return the word it yields.
  function automatic heap_result_t apply_heap_op(logic [MODE_W-1:0] mode,
                                                 logic signed [VALUE_W-1:0] value);
    heap_result_t res;
    bit           took_min;
    res      = '0;
    res.status = ST_OK;
    took_min = 1'b0;
    case (mode)
      MODE_INSERT, MODE_LOAD: begin
        if (shadow_count >= HEAP_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_count++;
          shadow_heap[shadow_count] = value;
          if (mode == MODE_INSERT)
            heap_float(shadow_count);
        end
      end
      MODE_EXTRACT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.min_value  = shadow_heap[1];
          took_min       = 1'b1;
          shadow_heap[1] = shadow_heap[shadow_count];
          shadow_count--;
          heap_sink(1);
        end
      end
      MODE_BUILD: begin
        for (int i = shadow_count / 2; i >= 1; i--)
          heap_sink(i);
      end
      MODE_VERIFY: begin
        if (!heap_is_ordered())
          res.status = ST_NOTHEAP;
      end
      default: ;
    endcase
    if (!took_min)
      res.min_value = (shadow_count > 0) ? shadow_heap[1] : '0;
    res.entry_count = shadow_count[ENTRY_W-1:0];
    return res;
  endfunction

  // Values lean on the extremes and on a narrow band so that ties occur.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      return VAL_MIN;
    if (r < 16)
      return VAL_MAX;
    if (r < 40)
      return int'($urandom_range(16)) - 8;
    return $urandom;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(op_mix_t mix);
    int r;
    int t_ins;
    int t_load;
    int t_ext;
    int t_ver;
    int t_bld;
    case (mix)
      MIX_FILL:  begin t_ins = 60; t_load = 70; t_ext = 82; t_ver = 88; t_bld = 93; end
      MIX_DRAIN: begin t_ins = 15; t_load = 20; t_ext = 80; t_ver = 88; t_bld = 93; end
      MIX_LOADS: begin t_ins = 15; t_load = 60; t_ext = 75; t_ver = 85; t_bld = 95; end
      default:   begin t_ins = 30; t_load = 45; t_ext = 70; t_ver = 82; t_bld = 92; end
    endcase
    r = $urandom_range(99);
    if (r < t_ins)  return MODE_INSERT;
    if (r < t_load) return MODE_LOAD;
    if (r < t_ext)  return MODE_EXTRACT;
    if (r < t_ver)  return MODE_VERIFY;
    if (r < t_bld)  return MODE_BUILD;
    case ($urandom_range(2))
      0:       return MODE_SPARE_LO;
      1:       return MODE_SPARE_MID;
      default: return MODE_SPARE_HI;
    endcase
  endfunction

  // Offer one word, wait for it to be taken, then record what it should yield.
  task automatic send_word(input logic [MODE_W-1:0] mode,
                           input logic signed [VALUE_W-1:0] value,
                           input bit typed, input heap_result_t want);
    heap_result_t predicted;
    if ($urandom_range(99) < idle_src_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_src_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_heap_op(mode, value);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Result-side back-pressure.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= idle_sink_pct);
    end
  end

  // Compare each result word with the oldest outstanding expectation.
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("unexpected result word: min %0d count %0d status %0d",
                   out_ch.min_value, out_ch.entry_count, out_ch.status);
      end else begin
        want = pending_results.pop_front();
        if (want.min_value !== out_ch.min_value || want.entry_count !== out_ch.entry_count ||
            want.status !== out_ch.status) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("result mismatch: expected min %0d count %0d status %0d, got min %0d count %0d status %0d",
                     want.min_value, want.entry_count, want.status,
                     out_ch.min_value, out_ch.entry_count, out_ch.status);
        end
      end
    end
  end

  // Watchdog: give up if neither channel moves a word for too long.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, three random phases, drain.
  initial begin
    op_mix_t mix;
    int      mix_left;
    mix_left = 0;
    mix      = MIX_BALANCED;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_INSERT;
    in_ch.value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].mode, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      // Receiver sparse then sender sparse, then both flat out.
      case (phase)
        0:       begin idle_src_pct = 6;  idle_sink_pct = 69; end
        1:       begin idle_src_pct = 69; idle_sink_pct = 6;  end
        default: begin idle_src_pct = 0;  idle_sink_pct = 0;  end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (mix_left == 0) begin
          mix      = op_mix_t'($urandom_range(3));
          mix_left = $urandom_range(160, 60);
        end
        mix_left--;
        send_word(pick_mode(mix), pick_value(), 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
